### rtl/spq_pkg.sv
// Package: sizes, codes and shared types of the stable sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 40;
    localparam int TAG_W = 16;
    localparam int OCC_W = 5;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_ENQ = 2'd0,
        ACT_DEQ = 2'd1,
        ACT_CLR = 2'd2,
        ACT_NOP = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // Broadcast from the controller to every cell
    typedef struct packed {
        t_cell_op         op;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_cell_cmd;

endpackage

### rtl/stable_sorted_priority_queue.sv
// The result of an item is registered as the item is accepted and shown from that register.
// Throughput: one item per cycle while results are taken; insert position is found by
// a compare in every cell at once, and the chain shifts by one slot in the same cycle.
// The next item is taken while a result waits, as long as that result leaves too.
// Reset (synchronous, active low) empties the queue and drops any pending result.
`timescale 1ns / 1ps

module stable_sorted_priority_queue import spq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_action,
    input  logic [KEY_W-1:0] i_key,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_status,
    output logic [KEY_W-1:0] o_removed_key,
    output logic [TAG_W-1:0] o_removed_tag,
    output logic [OCC_W-1:0] o_occupancy
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;
    logic [KEY_W-1:0] r_rkey;
    logic [KEY_W-1:0] n_rkey;
    logic [TAG_W-1:0] r_rtag;
    logic [TAG_W-1:0] n_rtag;
    logic [OCC_W-1:0] r_occ;

    logic             accept;
    t_action          act;
    t_cell_cmd        cmd;
    t_entry           entries [DEPTH];
    logic [DEPTH-1:0] le;
    logic [DEPTH-1:0] occ;

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_out_valid || i_ready;
    assign act     = t_action'(i_action);

    // Decode the item into a chain command and a result
    always_comb begin
        cmd.op  = CELL_HOLD;
        cmd.key = i_key;
        cmd.tag = i_tag;
        n_count  = r_count;
        n_status = ST_OK;
        n_rkey   = '0;
        n_rtag   = '0;
        unique case (act)
            ACT_ENQ: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.op  = CELL_INSERT;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_DEQ: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    cmd.op  = CELL_SHIFT;
                    n_count = r_count - CNT_W'(1);
                    n_rkey  = entries[0].key;
                    n_rtag  = entries[0].tag;
                end
            end
            ACT_CLR: begin
                n_count = '0;
            end
            ACT_NOP: begin
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        if (!accept) begin
            cmd.op = CELL_HOLD;
        end
    end

    // Chain of slots, head at index zero
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic   prev_le;
            t_entry prev_e;
            t_entry next_e;

            assign occ[g] = r_count > CNT_W'(g);

            if (g == 0) begin : g_head
                assign prev_le = 1'b1;
                assign prev_e  = '0;
            end else begin : g_body
                assign prev_le = le[g-1];
                assign prev_e  = entries[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign next_e = '0;
            end else begin : g_mid
                assign next_e = entries[g+1];
            end

            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_cmd     (cmd),
                .i_occ     (occ[g]),
                .i_prev_le (prev_le),
                .i_prev    (prev_e),
                .i_next    (next_e),
                .o_entry   (entries[g]),
                .o_le      (le[g])
            );
        end
    endgenerate

    // Count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_rkey   <= n_rkey;
            r_rtag   <= n_rtag;
            r_occ    <= OCC_W'(n_count);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_removed_key = r_rkey;
    assign o_removed_tag = r_rtag;
    assign o_occupancy   = r_occ;

endmodule

### rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it, shifts with neighbors.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  logic      i_occ,
    input  logic      i_prev_le,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    output t_entry    o_entry,
    output logic      o_le
);

    t_entry r_entry;
    t_entry n_entry;

    // Slot stays ahead of the new item when occupied and not larger
    assign o_le    = i_occ && (r_entry.key <= i_cmd.key);
    assign o_entry = r_entry;

    // Next slot content
    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.op)
            CELL_HOLD: begin
                n_entry = r_entry;
            end
            CELL_INSERT: begin
                if (o_le) begin
                    n_entry = r_entry;
                end else if (i_prev_le) begin
                    n_entry.key = i_cmd.key;
                    n_entry.tag = i_cmd.tag;
                end else begin
                    n_entry = i_prev;
                end
            end
            CELL_SHIFT: begin
                n_entry = i_next;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### dv/stable_sorted_priority_queue_test.sv
// Testbench: stable sorted priority queue checked against a shadow sorted list.
`timescale 1ns / 1ps

module stable_sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        t_action          act;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_request;

    typedef struct packed {
        t_status          status;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [OCC_W-1:0] occ;
    } t_reply;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [1:0]       i_action = ACT_NOP;
    logic [KEY_W-1:0] i_key = '0;
    logic [TAG_W-1:0] i_tag = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [1:0]       o_status;
    logic [KEY_W-1:0] o_removed_key;
    logic [TAG_W-1:0] o_removed_tag;
    logic [OCC_W-1:0] o_occupancy;

    t_request requests_todo[$];
    t_reply   replies_due[$];

    // Shadow copy of the sorted entries
    t_entry held[DEPTH];
    int     held_count = 0;

    int          total_requests = 0;
    int          accepted_count = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    t_request    in_flight;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    stable_sorted_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_tag         (i_tag),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_removed_key (o_removed_key),
        .o_removed_tag (o_removed_tag),
        .o_occupancy   (o_occupancy)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Gap before the next item; calm stretches have no gaps at all
    function automatic int unsigned draw_gap(inout bit calm);
        if ($urandom_range(0, 15) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return KEY_W'($urandom_range(0, 15));
            1: return ~KEY_W'($urandom_range(0, 15));
            default: return wide[KEY_W-1:0];
        endcase
    endfunction

    task automatic queue_request(t_action act, logic [KEY_W-1:0] key,
                                 logic [TAG_W-1:0] tag);
        t_request req;
        req.act = act;
        req.key = key;
        req.tag = tag;
        requests_todo.push_back(req);
    endtask

    // Apply one accepted item to the shadow list and queue its reply
    function automatic void apply_request(t_request req);
        t_reply res;
        int     pos;
        res.status = ST_OK;
        res.key = '0;
        res.tag = '0;
        case (req.act)
            ACT_ENQ: begin
                if (held_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // Stable insert: goes after every entry with key <= new key
                    pos = 0;
                    while (pos < held_count && held[pos].key <= req.key) pos++;
                    for (int i = held_count; i > pos; i--) held[i] = held[i-1];
                    held[pos].key = req.key;
                    held[pos].tag = req.tag;
                    held_count++;
                end
            end
            ACT_DEQ: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.key = held[0].key;
                    res.tag = held[0].tag;
                    for (int i = 1; i < held_count; i++) held[i-1] = held[i];
                    held_count--;
                end
            end
            ACT_CLR: held_count = 0;
            default: ;
        endcase
        res.occ = OCC_W'(held_count);
        replies_due.push_back(res);
    endfunction

    // Driver: presents items from the request queue with random gaps
    always @(posedge i_clk) begin : drive
        logic next_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            next_valid = i_valid;
            if (i_valid && o_ready) begin
                apply_request(in_flight);
                accepted_count++;
                next_valid = 1'b0;
                send_wait = draw_gap(send_calm);
            end
            if (!next_valid) begin
                if (send_wait != 0) begin
                    send_wait--;
                end else if (requests_todo.size() != 0) begin
                    in_flight = requests_todo.pop_front();
                    i_action <= in_flight.act;
                    i_key <= in_flight.key;
                    i_tag <= in_flight.tag;
                    next_valid = 1'b1;
                end
            end
            i_valid <= next_valid;
        end
    end

    // Monitor: takes replies with random back-pressure and checks them
    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (replies_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected reply: status %0d key %h tag %h occ %0d",
                                 $time, o_status, o_removed_key, o_removed_tag, o_occupancy);
                end else begin
                    want = replies_due.pop_front();
                    if (o_status !== want.status || o_removed_key !== want.key ||
                        o_removed_tag !== want.tag || o_occupancy !== want.occ) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: mismatch status exp %0d got %0d key exp %h got %h",
                                     $time, want.status, o_status, want.key, o_removed_key);
                            $display("%0t: mismatch tag exp %h got %h occ exp %0d got %0d",
                                     $time, want.tag, o_removed_tag, want.occ, o_occupancy);
                        end
                    end
                end
                recv_wait = draw_gap(recv_calm);
            end else if (recv_wait != 0) begin
                recv_wait--;
            end
            i_ready <= (recv_wait == 0);
        end
    end

    // Watchdog: no handshake on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int mode;

        // Directed: empty dequeue, ignored code, extremes, equal keys, full, clear
        queue_request(ACT_DEQ, '1, '1);
        queue_request(ACT_NOP, '1, '1);
        queue_request(ACT_ENQ, '1, 16'h0001);
        queue_request(ACT_ENQ, '0, 16'hFFFF);
        queue_request(ACT_ENQ, KEY_W'(5), 16'h00A1);
        queue_request(ACT_ENQ, KEY_W'(5), 16'h00A2);
        queue_request(ACT_ENQ, KEY_W'(5), 16'h00A3);
        queue_request(ACT_ENQ, '0, 16'h1234);
        queue_request(ACT_ENQ, '1, 16'h4321);
        for (int i = 0; i < 9; i++)
            queue_request(ACT_ENQ, KEY_W'($urandom_range(0, 7)), TAG_W'(16'hB000 + i));
        queue_request(ACT_ENQ, KEY_W'(3), 16'hDEAD);
        queue_request(ACT_DEQ, '0, '0);
        queue_request(ACT_DEQ, '0, '0);
        queue_request(ACT_CLR, '1, '1);
        queue_request(ACT_DEQ, '0, '0);
        queue_request(ACT_ENQ, '1, '1);
        queue_request(ACT_DEQ, '0, '0);

        // Random: mixed traffic, fill and drain bursts, clears, some noise
        while (requests_todo.size() < 425) begin
            mode = $urandom_range(0, 9);
            case (mode)
                0, 1, 2, 3: begin
                    repeat ($urandom_range(4, 16))
                        queue_request(($urandom_range(0, 9) < 6) ? ACT_ENQ : ACT_DEQ,
                                      pick_key(), TAG_W'($urandom_range(0, 65535)));
                end
                4, 5: begin
                    repeat ($urandom_range(12, 20))
                        queue_request(ACT_ENQ, pick_key(), TAG_W'($urandom_range(0, 65535)));
                end
                6, 7: begin
                    repeat ($urandom_range(12, 20))
                        queue_request(ACT_DEQ, pick_key(), TAG_W'($urandom_range(0, 65535)));
                end
                8: queue_request(ACT_CLR, pick_key(), TAG_W'($urandom_range(0, 65535)));
                default: begin
                    repeat ($urandom_range(1, 4))
                        queue_request(t_action'($urandom_range(0, 3)), pick_key(),
                                      TAG_W'($urandom_range(0, 65535)));
                end
            endcase
        end
        total_requests = requests_todo.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item and reply, then keep watching a while longer for strays
        do @(negedge i_clk);
        while (accepted_count != total_requests || replies_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && replies_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_sorted_priority_queue.sv
dv/stable_sorted_priority_queue_test.sv
